FILE: hw/rtl/nsrf_pkg.sv
`default_nettype none
package nsrf_pkg;

  localparam int MAX_SIDE    = 2048;
  localparam int STORE_DEPTH = 524288;
  localparam int SIDE_W      = 12;   // source side register width, holds MAX_SIDE
  localparam int COORD_W     = 11;   // coordinate width
  localparam int BOXW_W      = 10;
  localparam int BOXH_W      = 9;
  localparam int RGB_W       = 24;
  localparam int ARGB_W      = 32;
  localparam int MEM_AW      = $clog2(STORE_DEPTH);
  localparam int DVD_W       = 23;   // dividend width, 11x12 and 12x10 products
  localparam int PROD_W      = COORD_W + SIDE_W;
  localparam int CNT_W       = $clog2(DVD_W);
  localparam int DIV_STAGES  = COORD_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 12;

  localparam logic [SIDE_W-1:0] SIDE_MAX_V  = SIDE_W'(MAX_SIDE);
  localparam logic [BOXW_W-1:0] BOX_W_LIMIT = BOXW_W'(800);
  localparam logic [BOXH_W-1:0] BOX_H_LIMIT = BOXH_W'(340);
  localparam logic [7:0]        ALPHA_OPAQUE = 8'hff;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_BOX_WIDTH  = 3'd2,
    REG_BOX_HEIGHT = 3'd3,
    REG_ROTATE_CW  = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_READ  = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    FIT_IDLE,
    FIT_CHK1,
    FIT_DIV1,
    FIT_CHK2,
    FIT_DIV2
  } fit_state_t;

  typedef struct packed {
    logic               req_type;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [7:0]         red_in;
    logic [7:0]         green_in;
    logic [7:0]         blue_in;
  } in_item_t;

  typedef struct packed {
    logic [ARGB_W-1:0] argb;
    logic [BOXW_W-1:0] out_width;
    logic [BOXH_W-1:0] out_height;
    logic              status;
  } out_item_t;

  typedef struct packed {
    logic               req;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [RGB_W-1:0]   rgb;
    logic               bad;
  } pipe_t;

endpackage
`default_nettype wire

FILE: hw/rtl/nsrf_frame_mem.sv
`default_nettype none
module nsrf_frame_mem
  import nsrf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic              we,
  input  wire logic [MEM_AW-1:0] addr,
  input  wire logic [RGB_W-1:0]  wdata,
  output logic      [RGB_W-1:0]  rdata
);

  logic [RGB_W-1:0] mem [STORE_DEPTH];
  logic [RGB_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: hw/rtl/nsrf_div_pipe.sv
`default_nettype none
module nsrf_div_pipe
  import nsrf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [DVD_W-1:0]   dividend,
  input  wire logic [BOXW_W-1:0]  divisor,
  output logic      [COORD_W-1:0] quot
);

  // restoring divider, one quotient bit per stage, MSB first
  logic [DVD_W-1:0]   rem_r [DIV_STAGES];
  logic [COORD_W-1:0] q_r   [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    localparam int B = COORD_W - 1 - k;
    logic [DVD_W-1:0]   rin;
    logic [COORD_W-1:0] qin;
    logic [DVD_W-1:0]   trial;
    logic               ge;

    if (k == 0) begin : g_first
      assign rin = dividend;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_r[k-1];
      assign qin = q_r[k-1];
    end

    assign trial = DVD_W'(divisor) << B;
    assign ge    = (rin >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? (rin - trial) : rin;
        q_r[k]   <= qin | (COORD_W'(ge) << B);
      end
    end
  end

  assign quot = q_r[DIV_STAGES-1];

endmodule
`default_nettype wire

FILE: hw/rtl/nsrf_fit.sv
`default_nettype none
module nsrf_fit
  import nsrf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [SIDE_W-1:0] vw,
  input  wire logic [SIDE_W-1:0] vh,
  input  wire logic [BOXW_W-1:0] bw,
  input  wire logic [BOXH_W-1:0] bh,
  output logic      [BOXW_W-1:0] dw,
  output logic      [BOXH_W-1:0] dh,
  output logic                   busy
);

  fit_state_t        state_r, state_nxt;
  logic [SIDE_W-1:0] dw_r, dw_nxt, dh_r, dh_nxt;
  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [SIDE_W-1:0] rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic [SIDE_W:0]   rsh;
  logic              ge;
  logic [DVD_W-1:0]  dvd_step;
  logic [SIDE_W-1:0] q;
  logic              last;

  assign rsh      = {rem_r, dvd_r[DVD_W-1]};
  assign ge       = (rsh >= {1'b0, dvs_r});
  assign dvd_step = {dvd_r[DVD_W-2:0], ge};
  assign q        = dvd_step[SIDE_W-1:0];
  assign last     = (cnt_r == CNT_W'(DVD_W - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FIT_IDLE: state_nxt = FIT_IDLE;
      FIT_CHK1: state_nxt = (vw > SIDE_W'(bw)) ? FIT_DIV1 : FIT_CHK2;
      FIT_DIV1: if (last) state_nxt = FIT_CHK2;
      FIT_CHK2: state_nxt = (dh_r > SIDE_W'(bh)) ? FIT_DIV2 : FIT_IDLE;
      FIT_DIV2: if (last) state_nxt = FIT_IDLE;
      default:  state_nxt = FIT_IDLE;
    endcase
    if (start) state_nxt = FIT_CHK1;
  end

  always_comb begin
    dw_nxt  = dw_r;
    dh_nxt  = dh_r;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    unique case (state_r)
      FIT_CHK1: begin
        dw_nxt  = vw;
        dh_nxt  = vh;
        dvd_nxt = DVD_W'(vh) * DVD_W'(bw);
        dvs_nxt = vw;
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      FIT_CHK2: begin
        dvd_nxt = DVD_W'(vw) * DVD_W'(bh);
        dvs_nxt = vh;
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      FIT_DIV1, FIT_DIV2: begin
        rem_nxt = ge ? SIDE_W'(rsh - {1'b0, dvs_r}) : rsh[SIDE_W-1:0];
        dvd_nxt = dvd_step;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (last) begin
          if (state_r == FIT_DIV1) begin
            dh_nxt = (q == '0) ? SIDE_W'(1) : q;
            dw_nxt = SIDE_W'(bw);
          end else begin
            dw_nxt = (q == '0) ? SIDE_W'(1) : q;
            dh_nxt = SIDE_W'(bh);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FIT_CHK1;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dw_r  <= dw_nxt;
    dh_r  <= dh_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  assign busy = (state_r != FIT_IDLE);
  assign dw   = dw_r[BOXW_W-1:0];
  assign dh   = dh_r[BOXH_W-1:0];

endmodule
`default_nettype wire

FILE: hw/rtl/nearest_scale_rotate_pixel_fetch_top.sv
`default_nettype none
// Nearest-neighbor scale/rotate pixel fetch. A 512K x 24 frame store takes
// RGB source pixels written by (x, y) at y*src_width+x; a read transaction
// asks for one display pixel and returns opaque ARGB of the nearest source
// pixel plus the fitted display size. One transaction per clock while not
// stalled, through a 16-register pipe: input reg, product reg, an 11-stage
// pipelined divider (one quotient bit per stage), address multiply, address
// add, frame store read. Writes travel the same pipe and hit the store at the
// same stage as reads, so read-after-write order is kept without forwarding.
// After reset and after every cfg write the aspect-fit sequencer recomputes
// the display size with a shared bit-serial divider, with in_ready low.
// Out-of-range writes and reads give status 1; reads whose source address
// falls beyond the store give opaque black. Backpressure stalls the whole
// pipe (single enable).
module nearest_scale_rotate_pixel_fetch_top
  import nsrf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // config registers
  logic [SIDE_W-1:0] src_width_r, src_height_r;
  logic [BOXW_W-1:0] box_width_r;
  logic [BOXH_W-1:0] box_height_r;
  logic              rotate_cw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SIDE_W'(640);
      src_height_r <= SIDE_W'(480);
      box_width_r  <= BOX_W_LIMIT;
      box_height_r <= BOX_H_LIMIT;
      rotate_cw_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SRC_WIDTH:  src_width_r  <= cfg_wdata;
        REG_SRC_HEIGHT: src_height_r <= cfg_wdata;
        REG_BOX_WIDTH:  box_width_r  <= cfg_wdata[BOXW_W-1:0];
        REG_BOX_HEIGHT: box_height_r <= cfg_wdata[BOXH_W-1:0];
        REG_ROTATE_CW:  rotate_cw_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // clamped sizes and view
  logic [SIDE_W-1:0] sw, sh, vw, vh;
  logic [BOXW_W-1:0] bw, dw;
  logic [BOXH_W-1:0] bh, dh;
  logic              fit_busy;

  assign sw = (src_width_r == '0) ? SIDE_W'(1) :
              (src_width_r > SIDE_MAX_V) ? SIDE_MAX_V : src_width_r;
  assign sh = (src_height_r == '0) ? SIDE_W'(1) :
              (src_height_r > SIDE_MAX_V) ? SIDE_MAX_V : src_height_r;
  assign bw = (box_width_r == '0) ? BOXW_W'(1) :
              (box_width_r > BOX_W_LIMIT) ? BOX_W_LIMIT : box_width_r;
  assign bh = (box_height_r == '0) ? BOXH_W'(1) :
              (box_height_r > BOX_H_LIMIT) ? BOX_H_LIMIT : box_height_r;
  assign vw = rotate_cw_r ? sh : sw;
  assign vh = rotate_cw_r ? sw : sh;

  nsrf_fit u_fit (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cfg_we),
    .vw    (vw),
    .vh    (vh),
    .bw    (bw),
    .bh    (bh),
    .dw    (dw),
    .dh    (dh),
    .busy  (fit_busy)
  );

  // pipeline control: one enable for every stage
  logic en, accept;
  logic v5_r;

  assign en       = !v5_r || out_ready;
  assign in_ready = en && !fit_busy;
  assign accept   = in_valid && in_ready;

  // stage 1: capture and range check
  pipe_t s1_r, s1_nxt;
  logic  v1_r;

  always_comb begin
    s1_nxt.req = in_data.req_type;
    s1_nxt.x   = in_data.pos_x;
    s1_nxt.y   = in_data.pos_y;
    s1_nxt.rgb = {in_data.red_in, in_data.green_in, in_data.blue_in};
    if (in_data.req_type == REQ_WRITE) begin
      s1_nxt.bad = (SIDE_W'(in_data.pos_x) >= sw) || (SIDE_W'(in_data.pos_y) >= sh);
    end else begin
      s1_nxt.bad = (SIDE_W'(in_data.pos_x) >= SIDE_W'(dw)) ||
                   (SIDE_W'(in_data.pos_y) >= SIDE_W'(dh));
    end
  end

  // stage 2: dividends x*vw, y*vh
  pipe_t            s2_r;
  logic             v2_r;
  logic [DVD_W-1:0] px_r, py_r;

  // divider delay line
  pipe_t dl_r [DIV_STAGES];
  logic  dv_r [DIV_STAGES];
  logic [COORD_W-1:0] rx, ry;

  nsrf_div_pipe u_div_x (
    .clk      (clk),
    .en       (en),
    .dividend (px_r),
    .divisor  (dw),
    .quot     (rx)
  );

  nsrf_div_pipe u_div_y (
    .clk      (clk),
    .en       (en),
    .dividend (py_r),
    .divisor  (BOXW_W'(dh)),
    .quot     (ry)
  );

  // stage 3: source coordinate and row product
  pipe_t              s3_r, s3_in;
  logic               v3_r;
  logic [COORD_W-1:0] sx, sy, sx3_r;
  logic [PROD_W-1:0]  prod3_r;
  logic [SIDE_W-1:0]  sy_rot;

  assign s3_in  = dl_r[DIV_STAGES-1];
  assign sy_rot = sh - SIDE_W'(1) - SIDE_W'(rx);

  always_comb begin
    if (s3_in.req == REQ_WRITE) begin
      sx = s3_in.x;
      sy = s3_in.y;
    end else if (rotate_cw_r) begin
      sx = ry;
      sy = sy_rot[COORD_W-1:0];
    end else begin
      sx = rx;
      sy = ry;
    end
  end

  // stage 4: address and depth check
  pipe_t             s4_r;
  logic              v4_r, ok4_r;
  logic [MEM_AW-1:0] addr4_r;
  logic [PROD_W-1:0] addr4;

  assign addr4 = prod3_r + PROD_W'(sx3_r);

  // stage 5: frame store access
  pipe_t            s5_r;
  logic             ok5_r;
  logic [RGB_W-1:0] rd_data;
  logic             mem_we;

  assign mem_we = v4_r && (s4_r.req == REQ_WRITE) && !s4_r.bad && ok4_r;

  nsrf_frame_mem u_mem (
    .clk   (clk),
    .en    (en),
    .we    (mem_we),
    .addr  (addr4_r),
    .wdata (s4_r.rgb),
    .rdata (rd_data)
  );

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      for (int i = 0; i < DIV_STAGES; i++) dv_r[i] <= 1'b0;
    end else if (en) begin
      v1_r    <= accept;
      v2_r    <= v1_r;
      dv_r[0] <= v2_r;
      for (int i = 1; i < DIV_STAGES; i++) dv_r[i] <= dv_r[i-1];
      v3_r    <= dv_r[DIV_STAGES-1];
      v4_r    <= v3_r;
      v5_r    <= v4_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      s1_r    <= s1_nxt;
      s2_r    <= s1_r;
      px_r    <= DVD_W'(s1_r.x) * DVD_W'(vw);
      py_r    <= DVD_W'(s1_r.y) * DVD_W'(vh);
      dl_r[0] <= s2_r;
      for (int i = 1; i < DIV_STAGES; i++) dl_r[i] <= dl_r[i-1];
      s3_r    <= s3_in;
      sx3_r   <= sx;
      prod3_r <= PROD_W'(sy) * PROD_W'(sw);
      s4_r    <= s3_r;
      addr4_r <= addr4[MEM_AW-1:0];
      ok4_r   <= (addr4 < PROD_W'(STORE_DEPTH));
      s5_r    <= s4_r;
      ok5_r   <= ok4_r;
    end
  end

  // result
  always_comb begin
    out_data.out_width  = dw;
    out_data.out_height = dh;
    out_data.argb       = '0;
    out_data.status     = s5_r.bad;
    if (s5_r.req == REQ_WRITE) begin
      out_data.status = s5_r.bad || !ok5_r;
    end else if (!s5_r.bad) begin
      out_data.argb = {ALPHA_OPAQUE, ok5_r ? rd_data : RGB_W'(0)};
    end
  end

  assign out_valid = v5_r;

endmodule
`default_nettype wire
